// File: rtl/dq_pkg.sv
`default_nettype none
package dq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 64;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned CMD_W         = 3;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned COUNT_OUT_W   = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_BACK  = 3'd5,
    CMD_CLEAR      = 3'd6
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_FIN  = 1'b1
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic exec;
    logic load_out;
  } dq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
  } dq_sts_t;

endpackage
`default_nettype wire

// File: rtl/dq_ctrl.sv
`default_nettype none
module dq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire dq_pkg::dq_sts_t sts,
  output dq_pkg::dq_cmd_t      cmd
);
  import dq_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold until the result register can take the response
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.exec     = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.exec = in_valid;
      end
      S_FIN: begin
        cmd.load_out = sts.out_free;
      end
      default: ;
    endcase
  end

  a_exec_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> state_r == S_IDLE)
    else $error("request executed outside idle");

  a_exec_then_fin: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> state_r == S_FIN)
    else $error("executed request did not move to finish");

  a_fin_waits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && !sts.out_free |=> state_r == S_FIN)
    else $error("finish left while result register busy");

endmodule
`default_nettype wire

// File: rtl/dq_datapath.sv
`default_nettype none
module dq_datapath #(
  parameter int unsigned DEPTH = dq_pkg::DEPTH_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire dq_pkg::dq_cmd_t                   cmd,
  output dq_pkg::dq_sts_t                        sts,
  input  wire logic [dq_pkg::CMD_W-1:0]          in_command,
  input  wire logic signed [dq_pkg::WORD_W-1:0]  in_value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [dq_pkg::WORD_W-1:0]       out_read_word,
  output logic [dq_pkg::STATUS_W-1:0]            out_status,
  output logic [dq_pkg::COUNT_OUT_W-1:0]         out_entry_count
);
  import dq_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam logic [PW-1:0] LAST_POS   = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
  localparam logic [SW-1:0] DEPTH_S    = SW'(DEPTH);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] mem_q_r;

  logic [PW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // response info captured at execute
  status_t       rsp_status_r, rsp_status_nxt;
  logic          rsp_read_r, rsp_read_nxt;

  logic                 out_valid_r;
  logic [WORD_W-1:0]    out_word_r;
  status_t              out_status_r;
  logic [CW-1:0]        out_count_r;

  logic          wr_en, rd_en;
  logic [PW-1:0] wr_addr, rd_addr;
  logic          full, empty;
  logic [PW-1:0] head_inc, head_dec, tail_pos, back_pos;
  logic [SW-1:0] tail_sum, back_sum;
  cmd_t          op;

  assign op    = cmd_t'(in_command);
  assign full  = (count_r == FULL_COUNT);
  assign empty = (count_r == '0);

  assign head_inc = (head_r == LAST_POS) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? LAST_POS : head_r - 1'b1;

  assign tail_sum = SW'(head_r) + SW'(count_r);
  assign tail_pos = (tail_sum >= DEPTH_S) ? PW'(tail_sum - DEPTH_S) : PW'(tail_sum);
  // only used when not empty, so the sum never underflows
  assign back_sum = tail_sum - 1'b1;
  assign back_pos = (back_sum >= DEPTH_S) ? PW'(back_sum - DEPTH_S) : PW'(back_sum);

  always_comb begin
    head_nxt       = head_r;
    count_nxt      = count_r;
    rsp_status_nxt = rsp_status_r;
    rsp_read_nxt   = rsp_read_r;
    wr_en          = 1'b0;
    wr_addr        = tail_pos;
    rd_en          = 1'b0;
    rd_addr        = head_r;
    if (cmd.exec) begin
      rsp_status_nxt = ST_DONE;
      rsp_read_nxt   = 1'b0;
      case (op)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (full) begin
            rsp_status_nxt = ST_FULL;
          end else begin
            wr_en     = 1'b1;
            count_nxt = count_r + 1'b1;
            if (op == CMD_PUSH_FRONT) begin
              head_nxt = head_dec;
              wr_addr  = head_dec;
            end
          end
        end
        CMD_POP_FRONT, CMD_PEEK_FRONT: begin
          if (empty) begin
            rsp_status_nxt = ST_EMPTY;
          end else begin
            rd_en        = 1'b1;
            rsp_read_nxt = 1'b1;
            if (op == CMD_POP_FRONT) begin
              head_nxt  = head_inc;
              count_nxt = count_r - 1'b1;
            end
          end
        end
        CMD_POP_BACK, CMD_PEEK_BACK: begin
          if (empty) begin
            rsp_status_nxt = ST_EMPTY;
          end else begin
            rd_en        = 1'b1;
            rsp_read_nxt = 1'b1;
            rd_addr      = back_pos;
            if (op == CMD_POP_BACK) count_nxt = count_r - 1'b1;
          end
        end
        CMD_CLEAR: begin
          head_nxt  = '0;
          count_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= in_value;
    if (rd_en) mem_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rsp_status_r <= rsp_status_nxt;
    rsp_read_r   <= rsp_read_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_word_r   <= rsp_read_r ? mem_q_r : '0;
      out_status_r <= rsp_status_r;
      out_count_r  <= count_r;
    end
  end

  assign sts.out_free    = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_read_word   = out_word_r;
  assign out_status      = out_status_r;
  assign out_entry_count = COUNT_OUT_W'(out_count_r);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("entry count above depth");

  a_full_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && full && (op == CMD_PUSH_FRONT || op == CMD_PUSH_BACK)
    |=> count_r == $past(count_r) && head_r == $past(head_r))
    else $error("refused push changed the queue");

  a_pop_decrements: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && !empty && (op == CMD_POP_FRONT || op == CMD_POP_BACK)
    |=> count_r == $past(count_r) - 1'b1)
    else $error("pop did not drop one entry");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("result register loaded while busy");

endmodule
`default_nettype wire

// File: rtl/double_ended_queue_core.sv
`default_nettype none
// Double-ended queue of 32-bit signed words in a circular store of DEPTH
// entries (a single-port-write, registered-read memory). Each request names
// push front/back, pop front/back, peek front/back or clear, and yields
// exactly one response with the word read (zero unless a pop or peek
// succeeded), a status (done, empty, full) and the entry count after the
// request. The accepting cycle updates the pointers and issues the write
// or the read; the finish state then moves the registered read data into
// the response register once it is free, and a new request is taken only
// after that, back in idle. The response register decouples the sides: a
// request is accepted while the previous response still waits, and only
// a second finished response stalls on out_ready. No clearing pass after
// reset; entries are read only after being pushed. entry_count is 7 bits
// wide and exact for DEPTH up to 127.
module double_ended_queue_core #(
  parameter int unsigned DEPTH = dq_pkg::DEPTH_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [dq_pkg::CMD_W-1:0]          in_command,
  input  wire logic signed [dq_pkg::WORD_W-1:0]  in_value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [dq_pkg::WORD_W-1:0]       out_read_word,
  output logic [dq_pkg::STATUS_W-1:0]            out_status,
  output logic [dq_pkg::COUNT_OUT_W-1:0]         out_entry_count
);
  import dq_pkg::*;

  dq_cmd_t cmd;
  dq_sts_t sts;

  dq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_command      (in_command),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_word   (out_read_word),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

endmodule
`default_nettype wire
